// ===== src/crcpd_pkg.sv =====
package crcpd_pkg;

  localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;
  localparam int WORD_BITS = 64;
  localparam int WORD_BYTES = WORD_BITS / 8;
  localparam int LANES = 4;
  localparam logic [3:0] FULL_COUNT = 4'(WORD_BYTES);

  // CRC32C remainder after 64 reflected shift steps of a word that holds a
  // single one at bit position bit_pos.
  function automatic logic [31:0] crc_col(input int bit_pos);
    logic [63:0] c;
    c = 64'd1 << bit_pos;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ {32'd0, CRC32C_POLY};
      end else begin
        c = c >> 1;
      end
    end
    return c[31:0];
  endfunction

endpackage

// ===== src/crc32c_packet_digest_256_unit.sv =====
// An accepted input beat waits in the input register while the CRC and lane
// update is computed; a digest beat is then registered on the output lanes.
// Throughput: one word per cycle while no digest beat is stuck on out_ready;
// the running CRC and lane registers loop through the 64-bit CRC XOR network.
// Reset (rst, synchronous): clears the CRC, the digest lane accumulators, the
// word index and both valid flags.
module crc32c_packet_digest_256_unit
  import crcpd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        first_word,
  input  logic        last_word,
  input  logic [15:0] packet_kind,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_lane0,
  output logic [63:0] digest_lane1,
  output logic [63:0] digest_lane2,
  output logic [63:0] digest_lane3
);

  logic        stage_valid;
  logic [63:0] stage_data;
  logic [3:0]  stage_count;
  logic        stage_first;
  logic        stage_last;
  logic [15:0] stage_kind;

  logic [31:0] crc_running;
  logic [63:0] digest_acc [LANES];
  logic [2:0]  word_index;

  logic [31:0] crc_running_next;
  logic [63:0] digest_acc_next [LANES];
  logic [2:0]  word_index_next;

  logic        stage_full;
  logic        stage_emit;
  logic        stage_fire;
  logic        out_free;
  logic [31:0] crc_base;
  logic [2:0]  index_base;
  logic [63:0] packed_word;
  logic [63:0] crc_feed;
  logic [63:0] crc_xor;
  logic [31:0] crc_terms [WORD_BITS];
  logic [31:0] crc_new;

  assign stage_full = (stage_count >= FULL_COUNT);
  assign stage_emit = stage_last || !stage_full;
  assign out_free   = !out_valid || out_ready;
  assign stage_fire = stage_valid && (!stage_emit || out_free);
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_data  <= data_word;
      stage_count <= byte_count;
      stage_first <= first_word;
      stage_last  <= last_word;
      stage_kind  <= packet_kind;
    end
  end

  assign crc_base   = stage_first ? 32'd0 : crc_running;
  assign index_base = stage_first ? 3'd0 : word_index;

  // A closing partial word puts its first byte in the most significant
  // occupied byte position.
  always_comb begin
    packed_word = 64'd0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      if (4'(k) < stage_count) begin
        packed_word = {packed_word[55:0], stage_data[8*k +: 8]};
      end
    end
  end

  assign crc_feed = stage_full ? stage_data : packed_word;
  assign crc_xor  = {32'd0, crc_base} ^ crc_feed;

  for (genvar i = 0; i < WORD_BITS; i++) begin : g_crc_col
    localparam logic [31:0] COL = crc_col(i);
    assign crc_terms[i] = crc_xor[i] ? COL : 32'd0;
  end

  always_comb begin
    crc_new = 32'd0;
    for (int i = 0; i < WORD_BITS; i++) begin
      crc_new = crc_new ^ crc_terms[i];
    end
  end

  always_comb begin
    for (int q = 0; q < LANES; q++) begin
      digest_acc_next[q] = stage_first ? 64'd0 : digest_acc[q];
    end
    if (stage_first) begin
      digest_acc_next[LANES-1] = {48'd0, stage_kind};
    end
    crc_running_next = crc_base;
    word_index_next  = index_base;
    if (stage_count != 4'd0) begin
      crc_running_next = crc_new;
      if (index_base[0]) begin
        digest_acc_next[index_base[2:1]] = digest_acc_next[index_base[2:1]]
                                           ^ {crc_new, 32'd0};
      end else begin
        digest_acc_next[index_base[2:1]] = digest_acc_next[index_base[2:1]]
                                           ^ {32'd0, crc_new};
      end
      if (stage_full) begin
        digest_acc_next[index_base[1:0]] = digest_acc_next[index_base[1:0]]
                                           ^ stage_data;
        word_index_next = index_base + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running <= 32'd0;
      word_index  <= 3'd0;
      for (int q = 0; q < LANES; q++) begin
        digest_acc[q] <= 64'd0;
      end
    end else if (stage_fire) begin
      crc_running <= crc_running_next;
      word_index  <= word_index_next;
      for (int q = 0; q < LANES; q++) begin
        digest_acc[q] <= digest_acc_next[q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && stage_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_emit) begin
      digest_lane0 <= digest_acc_next[0];
      digest_lane1 <= digest_acc_next[1];
      digest_lane2 <= digest_acc_next[2];
      digest_lane3 <= digest_acc_next[3];
    end
  end

  a_emit_loads_output: assert property (@(posedge clk) disable iff (rst)
    stage_fire && stage_emit |=> out_valid)
    else $error("packet end did not produce a digest beat");

  a_full_word_advances_index: assert property (@(posedge clk) disable iff (rst)
    stage_fire && stage_full && !stage_first
      |=> word_index == $past(word_index) + 3'd1)
    else $error("full word did not advance the word index");

  a_partial_keeps_index: assert property (@(posedge clk) disable iff (rst)
    stage_fire && !stage_full && !stage_first |=> $stable(word_index))
    else $error("partial word changed the word index");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_fire |-> !in_ready)
    else $error("input accepted while the stage is stalled");

endmodule
